>>> rtl/urdc_pkg.sv
`default_nettype none

package urdc_pkg;

  localparam int unsigned WINDOW     = 5;
  localparam int unsigned TIMER_BITS = 16;

  localparam int unsigned TIME_W  = 16;
  localparam int unsigned SUM_W   = 20;
  localparam int unsigned LIM_W   = 8;
  localparam int unsigned BASE_W  = 15;
  localparam int unsigned TICK_W  = 14;
  localparam int unsigned LVL_W   = 7;
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned CNT_W   = $clog2(WINDOW + 1);
  localparam int unsigned DIV_BITS = SUM_W;
  localparam int unsigned STEP_W  = $clog2(DIV_BITS);

  // floor(x / WINDOW) == (x * AVG_RECIP) >> AVG_SHIFT for every SUM_W-bit x
  localparam int unsigned AVG_SHIFT = SUM_W + $clog2(WINDOW);
  localparam int unsigned PROD_W    = AVG_SHIFT + SUM_W;
  localparam logic [PROD_W-1:0] AVG_RECIP =
    PROD_W'(((64'd1 << AVG_SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

  localparam logic [TIME_W-1:0] TIME_MASK =
    TIME_W'((64'd1 << TIMER_BITS) - 64'd1);

  localparam logic CMD_EDGE   = 1'b0;
  localparam logic CMD_BUTTON = 1'b1;

  localparam logic REG_NEAR = 1'b0;
  localparam logic REG_FAR  = 1'b1;

  localparam logic [MODE_W-1:0] MODE_START = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ON    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RANGE = 2'd2;
  localparam logic [MODE_W-1:0] MODE_OFF   = 2'd3;

  localparam logic [TICK_W-1:0] CMP_START  = 14'd7500;
  localparam logic [TICK_W-1:0] CMP_ON     = 14'd700;
  localparam logic [TICK_W-1:0] CMP_OFF    = 14'd10000;
  localparam logic [TICK_W-1:0] GAP_NORMAL = 14'd1500;
  localparam logic [TICK_W-1:0] GAP_OFF    = 14'd1000;

  localparam logic [LVL_W-1:0] LVL_MAX = 7'd100;

  localparam logic [LVL_W-1:0] CURVE [101] = '{
    7'd0,  7'd14, 7'd18, 7'd21, 7'd24, 7'd26, 7'd27, 7'd29, 7'd30, 7'd32, 7'd33,
    7'd34, 7'd35, 7'd36, 7'd37, 7'd38, 7'd39, 7'd40, 7'd41, 7'd42, 7'd43, 7'd44,
    7'd44, 7'd45, 7'd46, 7'd47, 7'd48, 7'd48, 7'd49, 7'd50, 7'd50, 7'd51, 7'd52,
    7'd53, 7'd53, 7'd54, 7'd55, 7'd55, 7'd56, 7'd56, 7'd57, 7'd58, 7'd58, 7'd59,
    7'd60, 7'd60, 7'd61, 7'd61, 7'd62, 7'd62, 7'd63, 7'd64, 7'd64, 7'd65, 7'd66,
    7'd66, 7'd67, 7'd67, 7'd68, 7'd69, 7'd69, 7'd70, 7'd70, 7'd71, 7'd72, 7'd72,
    7'd73, 7'd73, 7'd74, 7'd74, 7'd75, 7'd76, 7'd76, 7'd77, 7'd78, 7'd78, 7'd79,
    7'd79, 7'd80, 7'd81, 7'd82, 7'd82, 7'd83, 7'd83, 7'd84, 7'd85, 7'd85, 7'd86,
    7'd87, 7'd88, 7'd88, 7'd89, 7'd90, 7'd91, 7'd92, 7'd93, 7'd94, 7'd95, 7'd96,
    7'd98, 7'd100
  };

  // firing delay for an accepted level: 100 * curve[100 - level]
  function automatic logic [TICK_W-1:0] level_delay(input logic [LVL_W-1:0] level);
    logic [LVL_W-1:0] idx;
    logic [LVL_W-1:0] c;
    begin
      idx = LVL_MAX - level;
      c   = (idx <= LVL_MAX) ? CURVE[idx] : '0;
      level_delay = TICK_W'(c * 14'd100);
    end
  endfunction

  function automatic logic [TICK_W-1:0] fire_cmp(input logic [MODE_W-1:0] mode,
                                                 input logic [TICK_W-1:0] delay);
    begin
      case (mode)
        MODE_ON:    fire_cmp = CMP_ON;
        MODE_RANGE: fire_cmp = delay;
        MODE_OFF:   fire_cmp = CMP_OFF;
        default:    fire_cmp = CMP_START;
      endcase
    end
  endfunction

  function automatic logic [TICK_W-1:0] reload_val(input logic [MODE_W-1:0] mode,
                                                   input logic [TICK_W-1:0] delay);
    begin
      reload_val = fire_cmp(mode, delay) + ((mode == MODE_OFF) ? GAP_OFF : GAP_NORMAL);
    end
  endfunction

  typedef struct packed {
    logic take;         // input beat accepted
    logic load_now;     // result of an accepted beat goes straight to output
    logic div_avg;      // load window sum
    logic avg_mul;      // scale window sum to the average
    logic div_lvl;      // load divider: (avg - base) / (far - near)
    logic div_step;     // one quotient bit
    logic commit_zero;  // accept level 0
    logic commit_q;     // accept level from quotient
    logic load_done;    // result of a finished window goes to output
  } urdc_cmd_t;

  typedef struct packed {
    logic win_done;     // incoming beat closes a window
    logic div_last;     // divider on its final step
    logic lim_bad;      // far limit not above near limit
    logic avg_le_base;  // average at or below near distance
    logic lvl_over;     // level above 100
    logic out_free;     // output register can take a result this edge
  } urdc_sts_t;

endpackage

`default_nettype wire

>>> rtl/urdc_ctrl.sv
`default_nettype none

module urdc_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  urdc_pkg::urdc_sts_t   sts_i,
  output urdc_pkg::urdc_cmd_t   cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_AVG,
    ST_CHECK,
    ST_DIV_LVL,
    ST_APPLY,
    ST_OUT
  } state_e;

  state_e state_q, state_d;
  logic   take;

  assign in_stall_o = !((state_q == ST_IDLE) && sts_i.out_free);
  assign take       = in_valid_i && !in_stall_o;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        cmd_o.take = take;
        if (take) begin
          if (sts_i.win_done) begin
            cmd_o.div_avg = 1'b1;
            state_d       = ST_AVG;
          end else begin
            cmd_o.load_now = 1'b1;
          end
        end
      end
      ST_AVG: begin
        cmd_o.avg_mul = 1'b1;
        state_d       = ST_CHECK;
      end
      ST_CHECK: begin
        if (sts_i.lim_bad) begin
          state_d = ST_OUT;
        end else if (sts_i.avg_le_base) begin
          cmd_o.commit_zero = 1'b1;
          state_d           = ST_OUT;
        end else begin
          cmd_o.div_lvl = 1'b1;
          state_d       = ST_DIV_LVL;
        end
      end
      ST_DIV_LVL: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) state_d = ST_APPLY;
      end
      ST_APPLY: begin
        cmd_o.commit_q = !sts_i.lvl_over;
        state_d        = ST_OUT;
      end
      ST_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.load_done = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/urdc_dp.sv
`default_nettype none

module urdc_dp (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic                           cfg_idx_i,
  input  wire logic [urdc_pkg::LIM_W-1:0]     cfg_wdata_i,
  input  wire logic                           cmd_i,
  input  wire logic [urdc_pkg::TIME_W-1:0]    capture_time_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic [urdc_pkg::MODE_W-1:0]         mode_o,
  output logic [urdc_pkg::TICK_W-1:0]         fire_compare_o,
  output logic [urdc_pkg::TICK_W-1:0]         period_reload_o,
  output logic [urdc_pkg::LVL_W-1:0]          level_percent_o,
  output logic                                level_updated_o,
  output logic                                ranging_enabled_o,
  input  urdc_pkg::urdc_cmd_t                 ctl_i,
  output urdc_pkg::urdc_sts_t                 sts_o
);

  localparam int unsigned REM_W = urdc_pkg::LIM_W;

  logic [urdc_pkg::LIM_W-1:0]   near_q, far_q;
  logic [urdc_pkg::MODE_W-1:0]  mode_q, mode_d;
  logic                         phase_q, phase_d;
  logic [urdc_pkg::TIME_W-1:0]  rise_q, rise_d;
  logic [urdc_pkg::CNT_W-1:0]   cnt_q, cnt_d;
  logic [urdc_pkg::SUM_W-1:0]   sum_q, sum_d;
  logic [urdc_pkg::LVL_W-1:0]   level_q;
  logic [urdc_pkg::TICK_W-1:0]  delay_q;
  logic                         upd_q;

  logic [urdc_pkg::SUM_W-1:0]   quot_q;
  logic [REM_W-1:0]             rem_q;
  logic [REM_W-1:0]             dvs_q;
  logic [urdc_pkg::STEP_W-1:0]  step_q;

  logic [urdc_pkg::TIME_W-1:0]  t;
  logic [urdc_pkg::SUM_W-1:0]   sum_new;
  logic [urdc_pkg::CNT_W:0]     cnt_new;
  logic                         pair_ok;
  logic                         win_done;
  logic [urdc_pkg::BASE_W-1:0]  base;
  logic [REM_W:0]               trial;
  logic                         trial_ge;
  logic [urdc_pkg::PROD_W-1:0]  avg_prod;
  logic [urdc_pkg::MODE_W-1:0]  out_mode;

  assign t        = capture_time_i & urdc_pkg::TIME_MASK;
  assign base     = urdc_pkg::BASE_W'(near_q * 15'd100);
  assign pair_ok  = (cmd_i == urdc_pkg::CMD_EDGE) && (mode_q == urdc_pkg::MODE_RANGE) &&
                    phase_q && (t > rise_q);
  assign sum_new  = sum_q + urdc_pkg::SUM_W'(t - rise_q);
  assign cnt_new  = {1'b0, cnt_q} + 1'b1;
  assign win_done = pair_ok && (cnt_new >= (urdc_pkg::CNT_W + 1)'(urdc_pkg::WINDOW));

  always_comb begin
    mode_d  = mode_q;
    phase_d = phase_q;
    rise_d  = rise_q;
    cnt_d   = cnt_q;
    sum_d   = sum_q;
    if (cmd_i == urdc_pkg::CMD_BUTTON) begin
      mode_d = (mode_q == urdc_pkg::MODE_OFF) ? urdc_pkg::MODE_ON : mode_q + 1'b1;
    end else if (mode_q == urdc_pkg::MODE_RANGE) begin
      if (!phase_q) begin
        rise_d  = t;
        phase_d = 1'b1;
      end else begin
        phase_d = 1'b0;
        if (pair_ok) begin
          if (win_done) begin
            cnt_d = '0;
            sum_d = '0;
          end else begin
            cnt_d = cnt_new[urdc_pkg::CNT_W-1:0];
            sum_d = sum_new;
          end
        end
      end
    end
  end

  // window average by reciprocal multiply
  assign avg_prod = urdc_pkg::PROD_W'(quot_q) * urdc_pkg::AVG_RECIP;

  // restoring divider, one quotient bit per step
  assign trial    = {rem_q, quot_q[urdc_pkg::SUM_W-1]};
  assign trial_ge = trial >= {1'b0, dvs_q};

  assign out_mode = ctl_i.load_now ? mode_d : mode_q;

  assign sts_o.win_done    = win_done;
  assign sts_o.div_last    = step_q == urdc_pkg::STEP_W'(urdc_pkg::DIV_BITS - 1);
  assign sts_o.lim_bad     = far_q <= near_q;
  assign sts_o.avg_le_base = quot_q <= urdc_pkg::SUM_W'(base);
  assign sts_o.lvl_over    = quot_q > urdc_pkg::SUM_W'(urdc_pkg::LVL_MAX);
  assign sts_o.out_free    = !out_valid_o || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      near_q      <= 8'd3;
      far_q       <= 8'd30;
      mode_q      <= urdc_pkg::MODE_START;
      phase_q     <= 1'b0;
      rise_q      <= '0;
      cnt_q       <= '0;
      sum_q       <= '0;
      level_q     <= '0;
      delay_q     <= '0;
      upd_q       <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == urdc_pkg::REG_FAR) far_q <= cfg_wdata_i;
        else                                near_q <= cfg_wdata_i;
      end
      if (ctl_i.take) begin
        mode_q  <= mode_d;
        phase_q <= phase_d;
        rise_q  <= rise_d;
        cnt_q   <= cnt_d;
        sum_q   <= sum_d;
        upd_q   <= 1'b0;
      end
      if (ctl_i.commit_zero) begin
        level_q <= '0;
        delay_q <= urdc_pkg::level_delay('0);
        upd_q   <= 1'b1;
      end else if (ctl_i.commit_q) begin
        level_q <= quot_q[urdc_pkg::LVL_W-1:0];
        delay_q <= urdc_pkg::level_delay(quot_q[urdc_pkg::LVL_W-1:0]);
        upd_q   <= 1'b1;
      end
      if (ctl_i.load_now || ctl_i.load_done) begin
        out_valid_o <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  // divider and output payload
  always_ff @(posedge clk_i) begin
    if (ctl_i.div_avg) begin
      quot_q <= sum_new;
    end else if (ctl_i.avg_mul) begin
      quot_q <= avg_prod[urdc_pkg::AVG_SHIFT +: urdc_pkg::SUM_W];
    end else if (ctl_i.div_lvl) begin
      quot_q <= quot_q - urdc_pkg::SUM_W'(base);
      rem_q  <= '0;
      dvs_q  <= far_q - near_q;
      step_q <= '0;
    end else if (ctl_i.div_step) begin
      quot_q <= {quot_q[urdc_pkg::SUM_W-2:0], trial_ge};
      rem_q  <= trial_ge ? REM_W'(trial - {1'b0, dvs_q}) : trial[REM_W-1:0];
      step_q <= step_q + 1'b1;
    end
    if (ctl_i.load_now || ctl_i.load_done) begin
      mode_o            <= out_mode;
      fire_compare_o    <= urdc_pkg::fire_cmp(out_mode, delay_q);
      period_reload_o   <= urdc_pkg::reload_val(out_mode, delay_q);
      level_percent_o   <= level_q;
      level_updated_o   <= ctl_i.load_done && upd_q;
      ranging_enabled_o <= out_mode == urdc_pkg::MODE_RANGE;
    end
  end

endmodule

`default_nettype wire

>>> rtl/ultrasonic_range_dimmer_control_top.sv
// channel  dir  handshake              payload
// in       in   in_valid_i/in_stall_o  cmd_i, capture_time_i
// out      out  out_valid_o/out_stall_i mode_o, fire_compare_o, period_reload_o,
//                                      level_percent_o, level_updated_o,
//                                      ranging_enabled_o
// cfg      in   cfg_we_i               cfg_idx_i, cfg_wdata_i
//
// A beat that does not close a window shows its result in the cycle after it is
// taken. A beat that closes a window passes ST_AVG, ST_CHECK and ST_OUT and,
// unless the level comes out zero or the limits are bad, the 20-step bit-serial
// level division; the window average is a constant reciprocal multiply. One item
// at a time; input stalls outside ST_IDLE or while a result is held.
// Reset (rst_ni low, async) clears mode, echo state and level; limits go to 3/30.
`default_nettype none

module ultrasonic_range_dimmer_control_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic                          cfg_idx_i,
  input  wire logic [urdc_pkg::LIM_W-1:0]    cfg_wdata_i,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic                          cmd_i,
  input  wire logic [urdc_pkg::TIME_W-1:0]   capture_time_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [urdc_pkg::MODE_W-1:0]        mode_o,
  output logic [urdc_pkg::TICK_W-1:0]        fire_compare_o,
  output logic [urdc_pkg::TICK_W-1:0]        period_reload_o,
  output logic [urdc_pkg::LVL_W-1:0]         level_percent_o,
  output logic                               level_updated_o,
  output logic                               ranging_enabled_o
);

  urdc_pkg::urdc_cmd_t cmd;
  urdc_pkg::urdc_sts_t sts;

  urdc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  urdc_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .cmd_i             (cmd_i),
    .capture_time_i    (capture_time_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .mode_o            (mode_o),
    .fire_compare_o    (fire_compare_o),
    .period_reload_o   (period_reload_o),
    .level_percent_o   (level_percent_o),
    .level_updated_o   (level_updated_o),
    .ranging_enabled_o (ranging_enabled_o),
    .ctl_i             (cmd),
    .sts_o             (sts)
  );

endmodule

`default_nettype wire

>>> rtl/urdc_chk.sv
`default_nettype none

module urdc_chk (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          in_stall_o,
  input wire logic                          out_valid_o,
  input wire logic                          out_stall_i,
  input wire logic [urdc_pkg::MODE_W-1:0]   mode_o,
  input wire logic [urdc_pkg::TICK_W-1:0]   fire_compare_o,
  input wire logic [urdc_pkg::TICK_W-1:0]   period_reload_o,
  input wire logic                          level_updated_o,
  input wire logic                          ranging_enabled_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  a_no_take_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> in_stall_o)
    else $error("input taken while result register is blocked");

  a_update_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && level_updated_o |->
      (mode_o == urdc_pkg::MODE_RANGE) && ranging_enabled_o)
    else $error("level update outside ranging mode");

  a_on_values: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (mode_o == urdc_pkg::MODE_ON) |->
      (fire_compare_o == urdc_pkg::CMP_ON) &&
      (period_reload_o == urdc_pkg::CMP_ON + urdc_pkg::GAP_NORMAL) &&
      !ranging_enabled_o)
    else $error("wrong timer values in light-on mode");

endmodule

bind ultrasonic_range_dimmer_control_top urdc_chk u_chk (.*);

`default_nettype wire
